// ===== design/dsrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrc_pkg
// Shared constants and types for the decimal string range checker.
// ----------------------------------------------------------------------------
package dsrc_pkg;

    localparam int CHAR_W = 8;
    localparam int MAG_W  = 64;
    localparam int RES_W  = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // Bound for one more digit: above it any digit overflows, at it only digits up to LIMIT_LAST_DIGIT fit
    localparam logic [MAG_W-1:0] MAG_LIMIT_DIV10 = 64'd1844674407370955161;
    localparam logic [3:0]       LIMIT_LAST_DIGIT = 4'd5;

    // Most negative signed magnitudes
    localparam logic [MAG_W-1:0] MAG_MIN_S32 = 64'h0000_0000_8000_0000;
    localparam logic [MAG_W-1:0] MAG_MIN_S64 = 64'h8000_0000_0000_0000;

    // Result flags; listed from highest bit down
    typedef struct packed {
        logic fits_unsigned64;
        logic fits_signed64;
        logic fits_unsigned32;
        logic fits_signed32;
        logic is_number;
    } result_t;

endpackage

// ===== design/decimal_string_range_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_string_range_checker
// Parses a decimal string one byte per request and reports, on the last
// byte, whether it is a number and which integer types hold its value.
// ----------------------------------------------------------------------------
// One request is taken every cycle. A request is captured in an input
// register; the held byte is then folded into the running state (sign, bad
// character, digit seen, 64-bit magnitude by times-ten-plus-digit, sticky
// overflow) and, on the last byte, writes the five flags into the output
// register. The output register lets the next string's bytes flow in while a
// result waits; only a last byte meeting an unaccepted result stalls the input.
module decimal_string_range_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [0:0]  s_tuser,   // [0] has_char
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] is_number, [1] fits_signed32,
                                   // [2] fits_unsigned32, [3] fits_signed64,
                                   // [4] fits_unsigned64, [7:5] zero
);
    import dsrc_pkg::*;

    // Input register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_has_reg;
    logic              in_last_reg;

    // String state
    logic             first_reg, first_next;
    logic             neg_reg, neg_next;
    logic             bad_reg, bad_next;
    logic             digit_reg, digit_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             ovf_reg, ovf_next;

    // Output register
    logic    out_valid_reg;
    result_t out_res_reg;

    logic             advance;
    logic             is_digit;
    logic [3:0]       digit;
    logic [MAG_W-1:0] mag_times10;
    result_t          res;
    logic             num;
    logic             ok_mag;

    // Move the held byte on unless it would close a string onto a full output
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_has_reg  <= s_tuser[0];
            in_last_reg <= s_tlast;
        end
    end

    // Fold one character into the string state
    assign is_digit    = (in_char_reg >= CHAR_ZERO) && (in_char_reg <= CHAR_NINE);
    assign digit       = 4'(in_char_reg - CHAR_ZERO);
    assign mag_times10 = {mag_reg[MAG_W-4:0], 3'b000} + {mag_reg[MAG_W-2:0], 1'b0};

    always_comb
    begin
        first_next = first_reg;
        neg_next   = neg_reg;
        bad_next   = bad_reg;
        digit_next = digit_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        if (in_has_reg)
        begin
            priority if (is_digit)
            begin
                mag_next   = mag_times10 + MAG_W'(digit);
                digit_next = 1'b1;
                if ((mag_reg > MAG_LIMIT_DIV10) ||
                    ((mag_reg == MAG_LIMIT_DIV10) && (digit > LIMIT_LAST_DIGIT)))
                begin
                    ovf_next = 1'b1;
                end
            end
            else if ((in_char_reg == CHAR_MINUS) && first_reg)
            begin
                neg_next = 1'b1;
            end
            else
            begin
                bad_next = 1'b1;
            end
            first_next = 1'b0;
        end
    end

    // Judge the finished string
    assign num    = !first_next && !bad_next;
    assign ok_mag = num && digit_next && !ovf_next;

    always_comb
    begin
        res.is_number = num;
        if (neg_next)
        begin
            res.fits_signed32   = ok_mag && ((mag_next[MAG_W-1:31] == '0) ||
                                             (mag_next == MAG_MIN_S32));
            res.fits_unsigned32 = 1'b0;
            res.fits_signed64   = ok_mag && (!mag_next[MAG_W-1] ||
                                             (mag_next == MAG_MIN_S64));
            res.fits_unsigned64 = 1'b0;
        end
        else
        begin
            res.fits_signed32   = ok_mag && (mag_next[MAG_W-1:31] == '0);
            res.fits_unsigned32 = ok_mag && (mag_next[MAG_W-1:32] == '0);
            res.fits_signed64   = ok_mag && !mag_next[MAG_W-1];
            res.fits_unsigned64 = ok_mag;
        end
    end

    // Update state; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            neg_reg   <= 1'b0;
            bad_reg   <= 1'b0;
            digit_reg <= 1'b0;
            mag_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                first_reg <= 1'b1;
                neg_reg   <= 1'b0;
                bad_reg   <= 1'b0;
                digit_reg <= 1'b0;
                mag_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                first_reg <= first_next;
                neg_reg   <= neg_next;
                bad_reg   <= bad_next;
                digit_reg <= digit_next;
                mag_reg   <= mag_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = RES_W'(out_res_reg);

    // A 64-bit type that holds the value implies a valid number
    a_u64_number: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[4] || m_tdata[3]) |-> m_tdata[0])
        else $error("range flag set on a non-number");

    // Narrower ranges nest inside wider ones
    a_nesting: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[1] || m_tdata[3]) && (!m_tdata[2] || m_tdata[4]))
        else $error("32-bit fit without 64-bit fit");

    // Closing a string returns the state to its start
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> first_reg && !neg_reg && !bad_reg && !digit_reg
                                   && !ovf_reg && (mag_reg == '0))
        else $error("string state not cleared");

    // A closed string always produces a pending result
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> out_valid_reg)
        else $error("result lost");

endmodule

// ===== sim/dsrc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrc_checker
// Watches both stream channels of the decimal string range checker, works
// out the range flags of every string it sees go in, and compares them with
// the results that come out, oldest first.
// ----------------------------------------------------------------------------
module dsrc_checker
    import dsrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [0:0]  s_tuser,   // [0] has_char
    input  logic        s_tlast,   // end_of_string
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [0] is_number, [1] fits_signed32,
                                   // [2] fits_unsigned32, [3] fits_signed64,
                                   // [4] fits_unsigned64, [7:5] zero
    output int          errors,
    output int          pending,
    output int          judged
);

    localparam logic [MAG_W-1:0] MAG_MAX_S32 = 64'h0000_0000_7FFF_FFFF;
    localparam logic [MAG_W-1:0] MAG_MAX_U32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [MAG_W-1:0] MAG_MAX_S64 = 64'h7FFF_FFFF_FFFF_FFFF;

    // Parse state of the string in flight
    logic             no_char_yet;
    logic             minus_lead;
    logic             junk_char;
    logic             got_digit;
    logic [MAG_W-1:0] value_mag;
    logic             value_ovf;

    result_t flags_q[$];

    function automatic void restart_string();
        no_char_yet = 1'b1;
        minus_lead  = 1'b0;
        junk_char   = 1'b0;
        got_digit   = 1'b0;
        value_mag   = '0;
        value_ovf   = 1'b0;
    endfunction

    // Fold one character into the running sign, digit and magnitude state
    function automatic void fold_char(input logic [CHAR_W-1:0] c);
        logic [3:0] d;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d = 4'(c - CHAR_ZERO);
            if (value_mag > MAG_LIMIT_DIV10 ||
                (value_mag == MAG_LIMIT_DIV10 && d > LIMIT_LAST_DIGIT))
                value_ovf = 1'b1;
            value_mag = value_mag * 64'd10 + {60'd0, d};
            got_digit = 1'b1;
        end
        else if (c == CHAR_MINUS && no_char_yet)
        begin
            minus_lead = 1'b1;
        end
        else
        begin
            junk_char = 1'b1;
        end
        no_char_yet = 1'b0;
    endfunction

    // Range flags of the string closed so far
    function automatic result_t range_flags();
        result_t r;
        logic    num;
        logic    ok;
        num = !no_char_yet && !junk_char;
        ok  = num && got_digit && !value_ovf;
        r.is_number = num;
        if (minus_lead)
        begin
            r.fits_signed32   = ok && (value_mag <= MAG_MIN_S32);
            r.fits_unsigned32 = 1'b0;
            r.fits_signed64   = ok && (value_mag <= MAG_MIN_S64);
            r.fits_unsigned64 = 1'b0;
        end
        else
        begin
            r.fits_signed32   = ok && (value_mag <= MAG_MAX_S32);
            r.fits_unsigned32 = ok && (value_mag <= MAG_MAX_U32);
            r.fits_signed64   = ok && (value_mag <= MAG_MAX_S64);
            r.fits_unsigned64 = ok;
        end
        return r;
    endfunction

    // Predict on each accepted request, compare on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            restart_string();
            flags_q.delete();
            errors  = 0;
            pending = 0;
            judged  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0])
                    fold_char(s_tdata);
                if (s_tlast)
                begin
                    flags_q.push_back(range_flags());
                    restart_string();
                    pending = pending + 1;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (flags_q.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("%t: result %h arrived with nothing expected",
                                 $realtime, m_tdata);
                end
                else
                begin
                    want    = flags_q.pop_front();
                    pending = pending - 1;
                    judged  = judged + 1;
                    if (m_tdata[0] !== want.is_number ||
                        m_tdata[1] !== want.fits_signed32 ||
                        m_tdata[2] !== want.fits_unsigned32 ||
                        m_tdata[3] !== want.fits_signed64 ||
                        m_tdata[4] !== want.fits_unsigned64 ||
                        m_tdata[7:5] !== 3'b000)
                    begin
                        errors = errors + 1;
                        // flags print from fits_unsigned64 down to is_number
                        if (errors <= 10)
                            $display("%t: flags u64..num expected %b got %b pad %b",
                                     $realtime, want, m_tdata[4:0], m_tdata[7:5]);
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives decimal strings into the range checker and gives the verdict.
// A short directed set covers empty strings, lone and misplaced minus signs,
// stray bytes and character-less requests; random strings then mix values
// around every type boundary, overflowing digit runs, corrupted numbers and
// raw byte noise, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    import dsrc_pkg::*;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam int                RAND_REQS  = 750;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] char_code
    logic [0:0]  s_tuser;    // [0] has_char
    logic        s_tlast;    // end_of_string
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [0] is_number, [1] fits_signed32,
                             // [2] fits_unsigned32, [3] fits_signed64,
                             // [4] fits_unsigned64, [7:5] zero

    int          errors;
    int          pending;
    int          judged;
    int          reqs_sent;
    int          strings_sent;
    bit          idle_on;
    bit          mix_gaps;
    logic [7:0]  text_q[$];

    decimal_string_range_checker dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dsrc_checker chk
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending),
        .judged   (judged)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the result channel at random while idling is on
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= !(idle_on && $urandom_range(99) < 18);
        end
    end

    // Bound the run
    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // Send one request; entered and left at a falling edge
    task automatic send_req(input logic [7:0] code, input logic has, input logic last);
        while (idle_on && $urandom_range(99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= has;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        reqs_sent = reqs_sent + 1;
    endtask

    task automatic put_text(input string t);
        for (int i = 0; i < t.len(); i++)
            text_q.push_back(t[i]);
    endtask

    // Send the buffered string, with optional character-less requests mixed in
    task automatic send_text();
        int n;
        n = text_q.size();
        if (n == 0) begin
            send_req(8'($urandom), 1'b0, 1'b1);
        end
        else begin
            for (int i = 0; i < n; i++)
            begin
                if (mix_gaps && $urandom_range(99) < 5)
                    send_req(8'($urandom), 1'b0, 1'b0);
                if (i == n - 1 && mix_gaps && $urandom_range(99) < 10) begin
                    send_req(text_q[i], 1'b1, 1'b0);
                    send_req(8'($urandom), 1'b0, 1'b1);
                end
                else begin
                    send_req(text_q[i], 1'b1, i == n - 1);
                end
            end
        end
        text_q.delete();
        strings_sent = strings_sent + 1;
    endtask

    // Hold the sender until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Well-formed number text with optional sign and leading zeros
    task automatic put_number(input logic [63:0] mag);
        if ($urandom_range(99) < 40)
            text_q.push_back(CHAR_MINUS);
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 3)) text_q.push_back(CHAR_ZERO);
        put_text($sformatf("%0d", mag));
    endtask

    task automatic make_random_string();
        int          kind;
        int          p;
        logic [63:0] mag;
        kind = $urandom_range(99);
        if (kind < 3) begin
            // empty string: nothing buffered
        end
        else if (kind < 35) begin
            mag = {$urandom, $urandom} >> $urandom_range(63);
            put_number(mag);
        end
        else if (kind < 60) begin
            case ($urandom_range(6))
                0:       mag = 64'd0;
                1:       mag = 64'h0000_0000_7FFF_FFFF;
                2:       mag = 64'h0000_0000_8000_0000;
                3:       mag = 64'h0000_0000_FFFF_FFFF;
                4:       mag = 64'h7FFF_FFFF_FFFF_FFFF;
                5:       mag = 64'h8000_0000_0000_0000;
                default: mag = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
            mag = mag + 64'($signed($urandom_range(4)) - 2);
            put_number(mag);
        end
        else if (kind < 72) begin
            if ($urandom_range(99) < 40)
                text_q.push_back(CHAR_MINUS);
            case ($urandom_range(2))
                0:       put_text($sformatf("%0d%0d", MAG_LIMIT_DIV10,
                                            $urandom_range(9)));
                1:       put_text($sformatf("%0d%0d", $urandom_range(9),
                                            {$urandom, $urandom}));
                default:
                    repeat ($urandom_range(20, 25))
                        text_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
            endcase
        end
        else if (kind < 85) begin
            // corrupt a number: a stray byte or a minus past the front
            put_number({$urandom, $urandom} >> $urandom_range(63));
            p = $urandom_range(text_q.size() - 1);
            if ($urandom_range(1))
                text_q[p] = 8'($urandom);
            else
                text_q.insert(p + 1, CHAR_MINUS);
        end
        else begin
            if ($urandom_range(1))
                text_q.push_back(CHAR_MINUS);
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        s_tlast      = 1'b0;
        idle_on      = 1'b1;
        mix_gaps     = 1'b0;
        reqs_sent    = 0;
        strings_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty, lone minus, minus zero, leading zeros, bad bytes
        send_text();
        put_text("-");   send_text();
        put_text("-0");  send_text();
        put_text("9");   send_text();
        put_text("-9");  send_text();
        put_text("00");  send_text();
        put_text("0-");  send_text();
        text_q.push_back(CHAR_SPACE); send_text();
        text_q.push_back(CHAR_DOT);   send_text();
        send_req(8'hFF, 1'b1, 1'b1);
        send_req(8'h00, 1'b1, 1'b1);
        // character-less requests inside a string and closing one
        send_req(CHAR_ZERO + 8'd1, 1'b1, 1'b0);
        send_req(8'hA5, 1'b0, 1'b0);
        send_req(CHAR_ZERO + 8'd2, 1'b1, 1'b1);
        send_req(CHAR_ZERO + 8'd5, 1'b1, 1'b0);
        send_req(8'h5A, 1'b0, 1'b1);
        drain();

        // Random strings: a stretch without idling, then idling on both sides
        mix_gaps = 1'b1;
        idle_on  = 1'b0;
        while (reqs_sent < RAND_REQS + 20)
        begin
            if (reqs_sent > 180)
                idle_on = 1'b1;
            if (strings_sent == 60)
                drain();
            make_random_string();
            send_text();
        end

        drain();
        repeat (8) @(posedge clk);
        $display("summary: %0d requests in %0d strings, %0d results checked",
                 reqs_sent, strings_sent, judged);
        $display("summary: boundary, overflow, corrupted and noise strings mixed");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
